/* hdl/twwa_pkg.sv */
// ----------------------------------------------------------------------------
// twwa_pkg
// Shared constants and types of the trade window weighted-average block.
// ----------------------------------------------------------------------------
package twwa_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned PriceW = 40;
  localparam int unsigned AccW   = 64;
  localparam int unsigned FracW  = 16;

  localparam logic [TimeW-1:0] DefaultSpan    = 32'd604800;
  localparam logic [TimeW-1:0] DefaultMinTime = 32'd1272000000;
  localparam logic [AccW-1:0]  AllOnes        = {AccW{1'b1}};

  // Register indexes of the configuration port.
  localparam logic [0:0] RegWindowSpan = 1'b0;
  localparam logic [0:0] RegMinTime    = 1'b1;

  // Input item codes.
  localparam logic OpTrade = 1'b0;
  localparam logic OpFlush = 1'b1;

  typedef struct packed {
    logic                  opcode;
    logic [TimeW-1:0]      trade_time;
    logic [PriceW-1:0]     trade_price;
    logic [PriceW-1:0]     trade_volume;
  } trade_t;

  typedef struct packed {
    logic [TimeW-1:0] window_start_time;
    logic [AccW-1:0]  volume_weighted_price;
    logic [AccW-1:0]  volume_sum;
    logic [AccW-1:0]  notional_weighted_price;
    logic [AccW-1:0]  notional_sum;
    logic [AccW-1:0]  recip_volume_weighted_price;
    logic [AccW-1:0]  recip_volume_sum;
    logic [AccW-1:0]  recip_notional_weighted_price;
    logic [AccW-1:0]  recip_notional_sum;
  } window_t;

  typedef struct packed {
    logic             index;
    logic [TimeW-1:0] data;
  } cfg_t;

  // Saturating add of two sums.
  function automatic logic [AccW-1:0] sat_add(input logic [AccW-1:0] a,
                                              input logic [AccW-1:0] b);
    logic [AccW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[AccW] ? AllOnes : s[AccW-1:0];
  endfunction

endpackage

/* hdl/twwa_if.sv */
// ----------------------------------------------------------------------------
// twwa_if
// Valid/ready channel carrying one request payload.
// ----------------------------------------------------------------------------
interface twwa_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/twwa_mul.sv */
// ----------------------------------------------------------------------------
// twwa_mul
// Shift-and-add multiplier, one multiplier bit per cycle, 128-bit product.
// ----------------------------------------------------------------------------
module twwa_mul
  import twwa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AccW-1:0]  a_i,
  input  logic [AccW-1:0]  b_i,
  output logic             done_o,
  output logic [2*AccW-1:0] prod_o
);
  logic [2*AccW-1:0] acc_q, acc_d;
  logic [2*AccW-1:0] mcand_q, mcand_d;
  logic [AccW-1:0]   mplier_q, mplier_d;
  logic [6:0]        cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;

  // One partial product per cycle, LSB of the multiplier first.
  always_comb begin
    acc_d = acc_q; mcand_d = mcand_q; mplier_d = mplier_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      acc_d = '0; mcand_d = {{AccW{1'b0}}, a_i}; mplier_d = b_i;
      cnt_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (mplier_q[0]) acc_d = acc_q + mcand_q;
      mcand_d  = mcand_q << 1;
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q + 7'd1;
      if (cnt_q == 7'(AccW - 1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; mcand_q <= mcand_d; mplier_q <= mplier_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;
endmodule

/* hdl/twwa_div.sv */
// ----------------------------------------------------------------------------
// twwa_div
// Restoring divider, one quotient bit per cycle: 128-bit dividend over a
// 64-bit divisor, quotient saturated to 64 bits.
// ----------------------------------------------------------------------------
module twwa_div
  import twwa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [2*AccW-1:0] num_i,
  input  logic [AccW-1:0]   den_i,
  output logic              done_o,
  output logic [AccW-1:0]   quot_o
);
  logic [2*AccW-1:0] num_q, num_d;
  logic [AccW:0]     rem_q, rem_d;
  logic [AccW-1:0]   den_q, den_d;
  logic [2*AccW-1:0] quo_q, quo_d;
  logic [7:0]        cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [AccW:0]     trial;

  // Shift in one dividend bit, subtract when it fits.
  always_comb begin
    num_d = num_q; rem_d = rem_q; den_d = den_q; quo_d = quo_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q[AccW-1:0], num_q[2*AccW-1]};
    if (start_i) begin
      num_d = num_i; den_d = den_i; rem_d = '0; quo_d = '0;
      cnt_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = num_q << 1;
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[2*AccW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[2*AccW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 8'd1;
      if (cnt_q == 8'(2*AccW - 1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; rem_q <= rem_d; den_q <= den_d; quo_q <= quo_d;
  end

  // Zero divisor or a quotient above 64 bits reads as all ones.
  assign done_o = done_q;
  assign quot_o = (den_q == '0 || quo_q[2*AccW-1:AccW] != '0) ? AllOnes
                                                              : quo_q[AccW-1:0];
endmodule

/* hdl/trade_window_weighted_average.sv */
// ----------------------------------------------------------------------------
// trade_window_weighted_average
// Groups trades into time windows and reports four saturating sums and four
// weighted averages per closed window.
// A trade that adds to the sums runs two bit-serial multiplies and three
// bit-serial divides; an emitting item runs four divides and the output
// state before that. One item at a time: no new item is taken until the
// last one is through and no result waits.
// Reset clears window state and loads the default span and minimum time.
// ----------------------------------------------------------------------------
module trade_window_weighted_average
  import twwa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  twwa_if.sink   cfg_i,
  twwa_if.sink   in_i,
  twwa_if.source out_o
);
  typedef enum logic [10:0] {
    StIdle   = 11'b00000000001,
    StMulNtl = 11'b00000000010,
    StMulPsq = 11'b00000000100,
    StDivRv  = 11'b00000001000,
    StDivRn  = 11'b00000010000,
    StDivPv  = 11'b00000100000,
    StEmit0  = 11'b00001000000,
    StEmit1  = 11'b00010000000,
    StEmit2  = 11'b00100000000,
    StEmit3  = 11'b01000000000,
    StOut    = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic [TimeW-1:0]  span_q, min_q, wstart_q, wstart_d;
  logic [AccW-1:0]   av_q, an_q, arv_q, arn_q, apsq_q, apv_q;
  logic [AccW-1:0]   av_d, an_d, arv_d, arn_d, apsq_d, apv_d;
  logic [PriceW-1:0] p_q, v_q;
  logic [AccW-1:0]   ntl_q, ntl_d;
  logic              ntl_hi_zero_q, ntl_hi_zero_d;
  logic              add_q, add_d;   // trade contributes after emit
  logic              reopen_q, reopen_d;
  logic              flush_q, flush_d;
  window_t           res_q, res_d;
  logic              ovalid_q, ovalid_d;

  // Divisor for 1/(P*V) needs the low product word, not the shifted one.
  logic [AccW-1:0]   plo_q;

  // Snapshot of the window being emitted.
  logic [AccW-1:0]   ev_q, en_q, erv_q, ern_q, epsq_q, epv_q;
  logic [TimeW-1:0]  est_q;
  logic              snap;

  logic              mul_start, mul_done, div_start, div_done;
  logic [AccW-1:0]   mul_a, mul_b, div_den, quot;
  logic [2*AccW-1:0] prod, div_num;

  twwa_mul u_mul (.clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
                  .done_o(mul_done), .prod_o(prod));
  twwa_div u_div (.clk_i, .rst_ni, .start_i(div_start), .num_i(div_num),
                  .den_i(div_den), .done_o(div_done), .quot_o(quot));

  logic [TimeW:0] wend;
  logic           emit_ok;
  assign wend    = {1'b0, wstart_q} + {1'b0, span_q};
  assign emit_ok = (wstart_q != '0) && (av_q != '0);

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == StIdle) && !ovalid_q;
  assign out_o.valid = ovalid_q;
  assign out_o.data  = res_q;

  // Sequencer.
  always_comb begin
    state_d = state_q; wstart_d = wstart_q;
    av_d = av_q; an_d = an_q; arv_d = arv_q; arn_d = arn_q;
    apsq_d = apsq_q; apv_d = apv_q;
    ntl_d = ntl_q; ntl_hi_zero_d = ntl_hi_zero_q;
    add_d = add_q; reopen_d = reopen_q; flush_d = flush_q;
    res_d = res_q; ovalid_d = ovalid_q;
    snap = 1'b0;
    mul_start = 1'b0; mul_a = '0; mul_b = '0;
    div_start = 1'b0; div_num = '0; div_den = '0;
    if (out_o.valid && out_o.ready) ovalid_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_i.valid && in_i.ready) begin
          if (in_i.data.opcode == OpFlush) begin
            flush_d = 1'b1; add_d = 1'b0; reopen_d = 1'b0;
            if (emit_ok) begin
              snap = 1'b1; state_d = StEmit0;
              div_start = 1'b1; div_num = {48'd0, an_q, 16'd0}; div_den = av_q;
            end
            wstart_d = '0;
            {av_d, an_d, arv_d, arn_d, apsq_d, apv_d} = '0;
          end else if (in_i.data.trade_time >= min_q) begin
            flush_d = 1'b0;
            add_d = (in_i.data.trade_price != '0) && (in_i.data.trade_volume != '0);
            reopen_d = {1'b0, in_i.data.trade_time} >= wend;
            if (reopen_d && emit_ok) begin
              snap = 1'b1; state_d = StEmit0;
              div_start = 1'b1; div_num = {48'd0, an_q, 16'd0}; div_den = av_q;
            end else if (add_d) begin
              state_d = StMulNtl;
              mul_start = 1'b1;
              mul_a = {24'd0, in_i.data.trade_price};
              mul_b = {24'd0, in_i.data.trade_volume};
            end
            if (reopen_d) begin
              wstart_d = in_i.data.trade_time;
              {av_d, an_d, arv_d, arn_d, apsq_d, apv_d} = '0;
            end
          end
        end
      end
      StEmit0: if (div_done) begin
        res_d.volume_weighted_price = quot;
        div_start = 1'b1; div_num = {48'd0, epsq_q, 16'd0}; div_den = en_q;
        state_d = StEmit1;
      end
      StEmit1: if (div_done) begin
        res_d.notional_weighted_price = quot;
        div_start = 1'b1; div_num = {48'd0, epv_q, 16'd0}; div_den = erv_q;
        state_d = StEmit2;
      end
      StEmit2: if (div_done) begin
        res_d.recip_volume_weighted_price = quot;
        div_start = 1'b1; div_num = {48'd0, erv_q, 16'd0}; div_den = ern_q;
        state_d = StEmit3;
      end
      StEmit3: if (div_done) begin
        res_d.recip_notional_weighted_price = quot;
        res_d.window_start_time  = est_q;
        res_d.volume_sum         = ev_q;
        res_d.notional_sum       = en_q;
        res_d.recip_volume_sum   = erv_q;
        res_d.recip_notional_sum = ern_q;
        state_d = StOut;
      end
      StOut: begin
        // Result register waits for the previous result to drain.
        if (!ovalid_q || (out_o.valid && out_o.ready)) begin
          ovalid_d = 1'b1;
          if (add_q && !flush_q) begin
            state_d = StMulNtl; mul_start = 1'b1;
            mul_a = {24'd0, p_q}; mul_b = {24'd0, v_q};
          end else begin
            state_d = StIdle;
          end
        end
      end
      StMulNtl: if (mul_done) begin
        ntl_hi_zero_d = (prod[2*AccW-1:AccW] == '0);
        ntl_d = (prod[2*AccW-1:AccW+FracW] != '0) ? AllOnes : prod[AccW+FracW-1:FracW];
        av_d = sat_add(av_q, {24'd0, v_q});
        an_d = sat_add(an_q, ntl_d);
        mul_start = 1'b1; mul_a = ntl_d; mul_b = {24'd0, p_q};
        state_d = StMulPsq;
      end
      StMulPsq: if (mul_done) begin
        apsq_d = sat_add(apsq_q, (prod[2*AccW-1:AccW+FracW] != '0) ? AllOnes
                                  : prod[AccW+FracW-1:FracW]);
        div_start = 1'b1; div_num = 128'd1 << 32; div_den = {24'd0, v_q};
        state_d = StDivRv;
      end
      StDivRv: if (div_done) begin
        arv_d = sat_add(arv_q, quot);
        div_start = 1'b1; div_num = 128'd1 << 48; div_den = plo_q;
        state_d = StDivRn;
      end
      StDivRn: if (div_done) begin
        // The quotient by the low product word is added only when the high word is zero.
        if (ntl_hi_zero_q) arn_d = sat_add(arn_q, quot);
        div_start = 1'b1; div_num = {64'd0, 8'd0, p_q, 16'd0};
        div_den = {24'd0, v_q};
        state_d = StDivPv;
      end
      StDivPv: if (div_done) begin
        apv_d = sat_add(apv_q, quot);
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; ovalid_q <= 1'b0;
      span_q <= DefaultSpan; min_q <= DefaultMinTime; wstart_q <= '0;
      {av_q, an_q, arv_q, arn_q, apsq_q, apv_q} <= '0;
      add_q <= 1'b0; reopen_q <= 1'b0; flush_q <= 1'b0;
    end else begin
      state_q <= state_d; ovalid_q <= ovalid_d; wstart_q <= wstart_d;
      av_q <= av_d; an_q <= an_d; arv_q <= arv_d; arn_q <= arn_d;
      apsq_q <= apsq_d; apv_q <= apv_d;
      add_q <= add_d; reopen_q <= reopen_d; flush_q <= flush_d;
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.data.index == RegWindowSpan)
          span_q <= (cfg_i.data.data == '0) ? DefaultSpan : cfg_i.data.data;
        else
          min_q <= cfg_i.data.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d; ntl_hi_zero_q <= ntl_hi_zero_d;
    ntl_q <= ntl_d;
    if (state_q == StMulNtl && mul_done) begin
      plo_q <= prod[AccW-1:0];
    end
    if (in_i.valid && in_i.ready) begin
      p_q <= in_i.data.trade_price; v_q <= in_i.data.trade_volume;
    end
    if (snap) begin
      est_q <= wstart_q; ev_q <= av_q; en_q <= an_q; erv_q <= arv_q;
      ern_q <= arn_q; epsq_q <= apsq_q; epv_q <= apv_q;
    end
  end
endmodule

/* hdl/twwa_checker.sv */
// ----------------------------------------------------------------------------
// twwa_checker
// Port-level checks of the trade window weighted-average block.
// ----------------------------------------------------------------------------
module twwa_checker
  import twwa_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input window_t out_data
);
  // A result waits until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // No new request is taken while a result still waits.
  a_no_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready)
    else $error("request taken while a result waits");

  // An emitted window always has a nonzero start and volume.
  a_guard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.window_start_time != '0 && out_data.volume_sum != '0)
    else $error("empty window emitted");

  // A request is only taken while the output side is empty.
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |-> !out_valid)
    else $error("request taken with a result on the output");
endmodule

bind trade_window_weighted_average twwa_checker u_twwa_checker (
  .clk_i, .rst_ni,
  .in_valid(in_i.valid), .in_ready(in_i.ready),
  .out_valid(out_o.valid), .out_ready(out_o.ready), .out_data(out_o.data)
);
